// ===== hw/rtl/nearest_object_follow_control_unit_assert.svh =====
// assertion macros for the nearest object follow control unit
// the asserting module provides clk_i and rst_ni
`ifndef NEAREST_OBJECT_FOLLOW_CONTROL_UNIT_ASSERT_SVH
`define NEAREST_OBJECT_FOLLOW_CONTROL_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked only while out of reset
`define NOFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define NOFC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define NOFC_ASSERT(label, prop, msg)
`define NOFC_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ===== hw/rtl/nofc_pkg.sv =====
package nofc_pkg;

  // field widths
  localparam int RANGE_W = 16;
  localparam int IDX_W   = 10;
  localparam int CNT_W   = 11;
  localparam int STEP_W  = 13;
  localparam int SPROD_W = STEP_W + IDX_W;
  localparam int B_W     = 25;
  localparam int PROD_W  = 37;
  localparam int LIN_W   = 24;
  localparam int ANG_W   = 28;

  // scan capacity
  localparam logic [CNT_W-1:0] MAX_BEAMS = 11'd1024;

  // range limits in mm
  localparam logic [RANGE_W-1:0] FLOOR_MM      = 16'd200;
  localparam logic [RANGE_W-1:0] SEEN_LIMIT_MM = 16'd12000;

  // angle constants in 2^-16 rad
  localparam logic signed [B_W-1:0] PI_FX      = 25'sd205887;
  localparam logic signed [B_W-1:0] NEG_PI_FX  = -25'sd205887;
  localparam logic signed [B_W-1:0] HALF_PI_FX = 25'sd102944;
  localparam logic signed [B_W-1:0] TWO_PI_FX  = 25'sd411775;

  // register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_FOLLOW_DIST  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FOLLOW_ANGLE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TURN_GAIN    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SPEED_GAIN   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_START_ANGLE  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ANGLE_STEP   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SENSOR_MIN   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SENSOR_MAX   = 3'd7;

  typedef struct packed {
    logic        [15:0] follow_distance_mm;
    logic signed [18:0] follow_angle;
    logic        [15:0] turn_gain;
    logic        [15:0] speed_gain;
    logic signed [19:0] scan_start_angle;
    logic        [12:0] beam_angle_step;
    logic        [15:0] sensor_min_mm;
    logic        [15:0] sensor_max_mm;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic accept_beam;
    logic clear_scan;
    logic calc_bearing;
    logic wrap_down;
    logic wrap_up;
    logic mul_lin;
    logic mul_ang;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic any_valid;
    logic above_pi;
    logic below_neg_pi;
  } dp_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WRAP,
    ST_MUL_LIN,
    ST_MUL_ANG,
    ST_FIN
  } state_e;

endpackage

// ===== hw/rtl/nofc_cfg_regs.sv =====
module nofc_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output nofc_pkg::cfg_t     cfg_o
);

  nofc_pkg::cfg_t cfg_q;
  logic [nofc_pkg::REG_IDX_W-1:0] reg_idx;
  logic wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg_o   = cfg_q;

  // register writes in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.follow_distance_mm <= 16'd1000;
      cfg_q.follow_angle       <= 19'sd0;
      cfg_q.turn_gain          <= 16'd256;
      cfg_q.speed_gain         <= 16'd128;
      cfg_q.scan_start_angle   <= -20'sd205887;
      cfg_q.beam_angle_step    <= 13'd402;
      cfg_q.sensor_min_mm      <= 16'd120;
      cfg_q.sensor_max_mm      <= 16'd12000;
    end else if (wr_en) begin
      unique case (reg_idx)
        nofc_pkg::REG_FOLLOW_DIST:  cfg_q.follow_distance_mm <= pwdata[15:0];
        nofc_pkg::REG_FOLLOW_ANGLE: cfg_q.follow_angle       <= signed'(pwdata[18:0]);
        nofc_pkg::REG_TURN_GAIN:    cfg_q.turn_gain          <= pwdata[15:0];
        nofc_pkg::REG_SPEED_GAIN:   cfg_q.speed_gain         <= pwdata[15:0];
        nofc_pkg::REG_START_ANGLE:  cfg_q.scan_start_angle   <= signed'(pwdata[19:0]);
        nofc_pkg::REG_ANGLE_STEP:   cfg_q.beam_angle_step    <= pwdata[12:0];
        nofc_pkg::REG_SENSOR_MIN:   cfg_q.sensor_min_mm      <= pwdata[15:0];
        nofc_pkg::REG_SENSOR_MAX:   cfg_q.sensor_max_mm      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back, signed registers sign extended
  always_comb begin
    unique case (reg_idx)
      nofc_pkg::REG_FOLLOW_DIST:  prdata = {16'd0, cfg_q.follow_distance_mm};
      nofc_pkg::REG_FOLLOW_ANGLE: prdata = {{13{cfg_q.follow_angle[18]}}, cfg_q.follow_angle};
      nofc_pkg::REG_TURN_GAIN:    prdata = {16'd0, cfg_q.turn_gain};
      nofc_pkg::REG_SPEED_GAIN:   prdata = {16'd0, cfg_q.speed_gain};
      nofc_pkg::REG_START_ANGLE:
        prdata = {{12{cfg_q.scan_start_angle[19]}}, cfg_q.scan_start_angle};
      nofc_pkg::REG_ANGLE_STEP:   prdata = {19'd0, cfg_q.beam_angle_step};
      nofc_pkg::REG_SENSOR_MIN:   prdata = {16'd0, cfg_q.sensor_min_mm};
      nofc_pkg::REG_SENSOR_MAX:   prdata = {16'd0, cfg_q.sensor_max_mm};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

// ===== hw/rtl/nofc_ctrl.sv =====
module nofc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  last_beam_i,
  input  logic                  out_stall_i,
  input  nofc_pkg::dp_status_t  status_i,
  output nofc_pkg::dp_cmd_t     cmd_o,
  output logic                  in_stall_o,
  output logic                  out_valid_o
);

  nofc_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != nofc_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nofc_pkg::ST_IDLE: begin
        if (in_valid_i && last_beam_i) state_d = nofc_pkg::ST_CHECK;
      end
      nofc_pkg::ST_CHECK: begin
        state_d = status_i.any_valid ? nofc_pkg::ST_WRAP : nofc_pkg::ST_IDLE;
      end
      nofc_pkg::ST_WRAP: begin
        if (!status_i.above_pi && !status_i.below_neg_pi) state_d = nofc_pkg::ST_MUL_LIN;
      end
      nofc_pkg::ST_MUL_LIN: state_d = nofc_pkg::ST_MUL_ANG;
      nofc_pkg::ST_MUL_ANG: state_d = nofc_pkg::ST_FIN;
      nofc_pkg::ST_FIN: begin
        if (out_free) state_d = nofc_pkg::ST_IDLE;
      end
      default: state_d = nofc_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      nofc_pkg::ST_IDLE:  cmd_o.accept_beam = in_valid_i;
      nofc_pkg::ST_CHECK: begin
        cmd_o.calc_bearing = status_i.any_valid;
        cmd_o.clear_scan   = !status_i.any_valid;
      end
      nofc_pkg::ST_WRAP: begin
        priority if (status_i.above_pi) cmd_o.wrap_down = 1'b1;
        else if (status_i.below_neg_pi) cmd_o.wrap_up = 1'b1;
        else cmd_o.wrap_up = 1'b0;
      end
      nofc_pkg::ST_MUL_LIN: cmd_o.mul_lin = 1'b1;
      nofc_pkg::ST_MUL_ANG: cmd_o.mul_ang = 1'b1;
      nofc_pkg::ST_FIN:     cmd_o.load_out = out_free;
      default: ;
    endcase
  end

  // result slot flag
  always_comb begin
    priority if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nofc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hw/rtl/nofc_datapath.sv =====
module nofc_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  nofc_pkg::cfg_t        cfg_i,
  input  nofc_pkg::dp_cmd_t     cmd_i,
  input  logic [15:0]           range_mm_i,
  input  logic                  range_finite_i,
  output nofc_pkg::dp_status_t  status_o,
  output logic signed [23:0]    linear_cmd_o,
  output logic signed [27:0]    angular_cmd_o,
  output logic                  object_seen_o,
  output logic [15:0]           nearest_range_o,
  output logic [9:0]            nearest_beam_o
);

  // scan search state
  logic [nofc_pkg::RANGE_W-1:0] best_q, best_d;
  logic [nofc_pkg::IDX_W-1:0]   idx_q, idx_d;
  logic [nofc_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic                         any_q, any_d;

  // bearing and multiply registers
  logic signed [nofc_pkg::B_W-1:0]    b_q, b_d;
  logic signed [nofc_pkg::PROD_W-1:0] prod_q, prod_d;
  logic signed [nofc_pkg::LIN_W-1:0]  lin_q;

  logic [nofc_pkg::RANGE_W-1:0] lo_lim;
  logic beam_ok, room, take;
  logic [nofc_pkg::SPROD_W-1:0] step_prod;
  logic signed [nofc_pkg::B_W-1:0] b_calc;
  logic signed [16:0] dist_err;
  logic signed [19:0] ang_err;
  logic signed [16:0] mul_a;
  logic signed [19:0] mul_b;
  logic signed [nofc_pkg::PROD_W-1:0] mul_p;
  logic signed [nofc_pkg::PROD_W-1:0] rnd;
  logic signed [28:0] rnd_sh;
  logic seen;

  function automatic logic signed [23:0] sat_lin(input logic signed [28:0] v);
    if (v > 29'sd8388607) return 24'sh7FFFFF;
    if (v < -29'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic logic signed [27:0] sat_ang(input logic signed [28:0] v);
    if (v > 29'sd134217727) return 28'sh7FFFFFF;
    if (v < -29'sd134217728) return 28'sh8000000;
    return v[27:0];
  endfunction

  // per beam range check and minimum search
  always_comb begin
    lo_lim  = (cfg_i.sensor_min_mm > nofc_pkg::FLOOR_MM) ? cfg_i.sensor_min_mm
                                                         : nofc_pkg::FLOOR_MM;
    beam_ok = range_finite_i && (range_mm_i >= lo_lim) && (range_mm_i <= cfg_i.sensor_max_mm);
    room    = cnt_q < nofc_pkg::MAX_BEAMS;
    take    = cmd_i.accept_beam && room && beam_ok && (!any_q || (range_mm_i < best_q));
    best_d  = best_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    any_d   = any_q;
    priority if (cmd_i.clear_scan || cmd_i.load_out) begin
      best_d = '1;
      idx_d  = '0;
      cnt_d  = '0;
      any_d  = 1'b0;
    end else if (cmd_i.accept_beam && room) begin
      cnt_d = cnt_q + 1'b1;
      if (take) begin
        best_d = range_mm_i;
        idx_d  = cnt_q[nofc_pkg::IDX_W-1:0];
        any_d  = 1'b1;
      end
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '1;
      idx_q  <= '0;
      cnt_q  <= '0;
      any_q  <= 1'b0;
    end else begin
      best_q <= best_d;
      idx_q  <= idx_d;
      cnt_q  <= cnt_d;
      any_q  <= any_d;
    end
  end

  // bearing of the nearest beam, wrapped one turn per cycle
  assign step_prod = nofc_pkg::SPROD_W'(cfg_i.beam_angle_step)
                   * nofc_pkg::SPROD_W'(idx_q);
  assign b_calc = {{5{cfg_i.scan_start_angle[19]}}, cfg_i.scan_start_angle}
                + signed'({2'b00, step_prod}) + nofc_pkg::HALF_PI_FX;

  always_comb begin
    b_d = b_q;
    priority if (cmd_i.calc_bearing) b_d = b_calc;
    else if (cmd_i.wrap_down) b_d = b_q - nofc_pkg::TWO_PI_FX;
    else if (cmd_i.wrap_up) b_d = b_q + nofc_pkg::TWO_PI_FX;
    else b_d = b_q;
  end

  // shared multiplier for both command products
  assign dist_err = signed'({1'b0, best_q}) - signed'({1'b0, cfg_i.follow_distance_mm});
  assign ang_err  = signed'(b_q[19:0]) - {cfg_i.follow_angle[18], cfg_i.follow_angle};
  assign mul_a    = cmd_i.mul_lin ? signed'({1'b0, cfg_i.speed_gain})
                                  : signed'({1'b0, cfg_i.turn_gain});
  assign mul_b    = cmd_i.mul_lin ? {{3{dist_err[16]}}, dist_err} : ang_err;
  assign mul_p    = mul_a * mul_b;
  assign prod_d   = (cmd_i.mul_lin || cmd_i.mul_ang) ? mul_p : prod_q;

  // round half up and drop the eight fraction bits
  assign rnd    = prod_q + 37'sd128;
  assign rnd_sh = rnd[36:8];
  assign seen   = best_q < nofc_pkg::SEEN_LIMIT_MM;

  always_ff @(posedge clk_i) begin
    b_q    <= b_d;
    prod_q <= prod_d;
    if (cmd_i.mul_ang) lin_q <= sat_lin(rnd_sh);
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      linear_cmd_o    <= seen ? lin_q : '0;
      angular_cmd_o   <= seen ? sat_ang(rnd_sh) : '0;
      object_seen_o   <= seen;
      nearest_range_o <= best_q;
      nearest_beam_o  <= idx_q;
    end
  end

  assign status_o.any_valid    = any_q;
  assign status_o.above_pi     = b_q > nofc_pkg::PI_FX;
  assign status_o.below_neg_pi = b_q < nofc_pkg::NEG_PI_FX;

endmodule

// ===== hw/rtl/nearest_object_follow_control_unit.sv =====
// Nearest object follower for a lidar scan.
// Input channel (in_valid_i / in_stall_o) moves one beam per transfer:
// range_mm_i, range_finite_i and last_beam_i. Beams are searched for the
// first strictly smallest valid range; one beam is taken per cycle while
// the input is not stalled. After the transfer carrying last_beam_i the
// block stalls its input while it finishes the scan: it checks for a valid
// beam and forms the bearing, then wraps it one 2*pi correction at a time
// (at most 22 for any register setting, 0 or 1 for a normal scan span), then
// uses one shared 17x20 multiplier and the rounding logic. A scan ending with
// no valid beam returns to idle after the check cycle and gives no result.
// The result channel (out_valid_o / out_stall_i) holds one result in its
// output register; while it waits, the next scan's beams are still taken,
// and only the final step of the next scan waits for the slot to free up.
// Configuration must be written over the APB port only while the block is
// idle; the block itself does not enforce this. Reset (rst_ni low) restores
// register defaults and clears the scan state and the result slot.
`include "nearest_object_follow_control_unit_assert.svh"

module nearest_object_follow_control_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        range_mm_i,
  input  logic               range_finite_i,
  input  logic               last_beam_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] linear_cmd_o,
  output logic signed [27:0] angular_cmd_o,
  output logic               object_seen_o,
  output logic [15:0]        nearest_range_o,
  output logic [9:0]         nearest_beam_o
);

  nofc_pkg::cfg_t       cfg;
  nofc_pkg::dp_cmd_t    cmd;
  nofc_pkg::dp_status_t status;

  // configuration registers
  nofc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer
  nofc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_beam_i (last_beam_i),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  // search, bearing and command arithmetic
  nofc_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .range_mm_i      (range_mm_i),
    .range_finite_i  (range_finite_i),
    .status_o        (status),
    .linear_cmd_o    (linear_cmd_o),
    .angular_cmd_o   (angular_cmd_o),
    .object_seen_o   (object_seen_o),
    .nearest_range_o (nearest_range_o),
    .nearest_beam_o  (nearest_beam_o)
  );

  // checks
  `NOFC_ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd), "more than one datapath command")
  `NOFC_ASSERT(a_last_stalls, in_valid_i && !in_stall_o && last_beam_i |=> in_stall_o,
               "input not stalled after last beam")
  `NOFC_ASSERT(a_load_valid, cmd.load_out |=> out_valid_o, "loaded result not presented")
  `NOFC_ASSERT(a_far_zero,
               out_valid_o && !object_seen_o |-> linear_cmd_o == 0 && angular_cmd_o == 0,
               "far object with nonzero command")

endmodule
